// ===== rtl/core/axis_cumulative_sum_assert.svh =====
// Assertion macros for the axis cumulative sum block.
`ifndef AXIS_CUMULATIVE_SUM_ASSERT_SVH
`define AXIS_CUMULATIVE_SUM_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define ACS_ASSERT_IMP(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define ACS_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/acs_pkg.sv =====
// Shared constants, types and codes of the axis cumulative sum block.
package acs_pkg;

    localparam int MAX_ELEMS  = 4096;
    localparam int DATA_WIDTH = 32;

    localparam int ELEM_W     = 32;
    localparam int SUM_W      = 44;
    localparam int CNT_W      = 13;
    localparam int POS_W      = 12;
    localparam int IDX_W      = 12;
    localparam int ADDR_W     = $clog2(MAX_ELEMS);
    localparam int LOAD_W     = ADDR_W + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    // intermediate product widths of the address and size arithmetic
    localparam int P1_W  = 2 * CNT_W;
    localparam int T1_W  = POS_W + CNT_W + 1;
    localparam int TOT_W = 3 * CNT_W;
    localparam int AP_W  = T1_W + CNT_W;

    typedef enum logic
    {
        OP_LOAD  = 1'b0,
        OP_FETCH = 1'b1
    } opcode_t;

    typedef enum logic [CFG_IDX_W-1:0]
    {
        CFG_OUTER_COUNT    = 3'd0,
        CFG_AXIS_LENGTH    = 3'd1,
        CFG_INNER_COUNT    = 3'd2,
        CFG_EXCLUSIVE_MODE = 3'd3,
        CFG_REVERSE_MODE   = 3'd4
    } cfg_reg_t;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_CALC1,
        ST_CALC2,
        ST_READ,
        ST_SUM,
        ST_EMIT,
        ST_EMIT_NODATA
    } state_t;

    typedef struct packed
    {
        logic load;
        logic calc1;
        logic calc2;
        logic read;
        logic sum;
        logic emit;
        logic emit_nodata;
    } cmd_t;

    typedef struct packed
    {
        logic ok;
        logic out_free;
    } stat_t;

endpackage

// ===== rtl/core/axis_cumulative_sum.sv =====
// Running sum along one axis of a tensor held in an on-chip element buffer.
// A load transaction (opcode 0) stores one element while the buffer has room, and loads
// may follow every cycle while no fetch is in progress. A fetch transaction (opcode 1)
// runs the address and tensor-size multiplies (CALC1, CALC2), a registered buffer read,
// an accumulate, and the hand-over of the result to the output register, which waits
// while the output is stalled; a no-data answer skips the accumulate. The output register
// holds the result while the next transaction is taken. The buffer needs no clearing;
// writes to a defined config register restart the walk but keep the loaded elements.
module axis_cumulative_sum
    import acs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  opcode,
    input  logic [ELEM_W-1:0]     element,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [SUM_W-1:0]      sum_value,
    output logic [IDX_W-1:0]      flat_index,
    output logic                  last,
    output logic                  status,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

`include "axis_cumulative_sum_assert.svh"

    cmd_t  cmd;
    stat_t stat;

    acs_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .opcode   (opcode),
        .stat     (stat),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    acs_datapath u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .element    (element),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .sum_value  (sum_value),
        .flat_index (flat_index),
        .last       (last),
        .status     (status)
    );

    `ACS_ASSERT_NEXT(a_load_keeps_ready, clk, rst_n, in_valid && !in_stall && opcode == OP_LOAD, !in_stall, "load transaction left the block busy")
    `ACS_ASSERT_NEXT(a_fetch_goes_busy, clk, rst_n, in_valid && !in_stall && opcode == OP_FETCH, in_stall, "fetch transaction did not start a fetch")
    `ACS_ASSERT_NEXT(a_emit_shows_result, clk, rst_n, (cmd.emit || cmd.emit_nodata) && stat.out_free, out_valid, "result not presented after emit")
    `ACS_ASSERT_IMP(a_nodata_is_zero, clk, rst_n, out_valid && status, sum_value == '0 && flat_index == '0 && !last, "no-data result carries payload")

endmodule

// ===== rtl/core/acs_ctrl.sv =====
// Controller state machine: input handshake and sequencing of one fetch.
module acs_ctrl
    import acs_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  logic  opcode,
    input  stat_t stat,
    output logic  in_stall,
    output cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign accept = in_valid && (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (opcode == OP_FETCH))
                begin
                    state_next = ST_CALC1;
                end
            end
            ST_CALC1:
            begin
                state_next = ST_CALC2;
            end
            ST_CALC2:
            begin
                state_next = ST_READ;
            end
            ST_READ:
            begin
                state_next = stat.ok ? ST_SUM : ST_EMIT_NODATA;
            end
            ST_SUM:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT, ST_EMIT_NODATA:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = accept && (opcode == OP_LOAD);
            end
            ST_CALC1:       cmd.calc1       = 1'b1;
            ST_CALC2:       cmd.calc2       = 1'b1;
            ST_READ:        cmd.read        = 1'b1;
            ST_SUM:         cmd.sum         = 1'b1;
            ST_EMIT:        cmd.emit        = 1'b1;
            ST_EMIT_NODATA: cmd.emit_nodata = 1'b1;
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== rtl/core/acs_datapath.sv =====
// Datapath: config registers, element buffer, walk state, sum and output register.
module acs_datapath
    import acs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  cmd,
    output stat_t                 stat,
    input  logic [ELEM_W-1:0]     element,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  out_stall,
    output logic                  out_valid,
    output logic [SUM_W-1:0]      sum_value,
    output logic [IDX_W-1:0]      flat_index,
    output logic                  last,
    output logic                  status
);

    logic [CNT_W-1:0]      outer_count_reg;
    logic [CNT_W-1:0]      axis_length_reg;
    logic [CNT_W-1:0]      inner_count_reg;
    logic                  exclusive_mode_reg;
    logic                  reverse_mode_reg;

    logic [DATA_WIDTH-1:0] mem [MAX_ELEMS];
    logic [DATA_WIDTH-1:0] rd_data_reg;

    logic [LOAD_W-1:0]     load_count_reg;
    logic [POS_W-1:0]      outer_pos_reg;
    logic [POS_W-1:0]      inner_pos_reg;
    logic [POS_W-1:0]      axis_step_reg;
    logic [SUM_W-1:0]      running_sum_reg;
    logic [ADDR_W-1:0]     prev_pos_reg;

    logic [P1_W-1:0]       p1_reg;
    logic [T1_W-1:0]       t1_reg;
    logic [TOT_W-1:0]      total_reg;
    logic [ADDR_W-1:0]     addr_reg;

    logic                  out_valid_reg;
    logic [SUM_W-1:0]      out_sum_reg;
    logic [IDX_W-1:0]      out_index_reg;
    logic                  out_last_reg;
    logic                  out_status_reg;

    logic                  room;
    logic                  cfg_hit;
    logic [CNT_W-1:0]      rev_pos;
    logic [POS_W-1:0]      pos;
    logic [AP_W-1:0]       addr_full;
    logic [ADDR_W-1:0]     rd_addr;
    logic [SUM_W-1:0]      elem_ext;
    logic [SUM_W-1:0]      sum_next;
    logic [CNT_W-1:0]      step_inc;
    logic [CNT_W-1:0]      inner_inc;
    logic [CNT_W-1:0]      outer_inc;
    logic                  line_end;
    logic                  plane_end;
    logic                  walk_end;
    logic                  commit;

    assign room    = load_count_reg < LOAD_W'(MAX_ELEMS);
    assign cfg_hit = cfg_wr_en && (cfg_index <= CFG_REVERSE_MODE);

    assign rev_pos = axis_length_reg - CNT_W'(1) - {1'b0, axis_step_reg};
    assign pos     = reverse_mode_reg ? rev_pos[POS_W-1:0] : axis_step_reg;

    assign addr_full = AP_W'(t1_reg) * AP_W'(inner_count_reg) + AP_W'(inner_pos_reg);

    // exclusive sums add the element one step behind
    assign rd_addr = (exclusive_mode_reg && (axis_step_reg != '0)) ? prev_pos_reg : addr_reg;

    assign elem_ext = {{(SUM_W-DATA_WIDTH){rd_data_reg[DATA_WIDTH-1]}}, rd_data_reg};

    always_comb
    begin
        if (axis_step_reg == '0)
        begin
            sum_next = exclusive_mode_reg ? '0 : elem_ext;
        end
        else
        begin
            sum_next = running_sum_reg + elem_ext;
        end
    end

    assign step_inc  = {1'b0, axis_step_reg} + CNT_W'(1);
    assign inner_inc = {1'b0, inner_pos_reg} + CNT_W'(1);
    assign outer_inc = {1'b0, outer_pos_reg} + CNT_W'(1);
    assign line_end  = step_inc >= axis_length_reg;
    assign plane_end = line_end && (inner_inc >= inner_count_reg);
    assign walk_end  = plane_end && (outer_inc >= outer_count_reg);

    assign stat.ok = (total_reg != '0) && (total_reg <= TOT_W'(MAX_ELEMS))
                     && (TOT_W'(load_count_reg) >= total_reg);
    assign stat.out_free = !out_valid_reg || !out_stall;

    assign commit = cmd.emit && stat.out_free;

    always_ff @(posedge clk)
    begin
        if (cmd.load && room)
        begin
            mem[load_count_reg[ADDR_W-1:0]] <= element[DATA_WIDTH-1:0];
        end
        if (cmd.read)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.calc1)
        begin
            p1_reg <= P1_W'(outer_count_reg) * P1_W'(axis_length_reg);
            t1_reg <= T1_W'(outer_pos_reg) * T1_W'(axis_length_reg) + T1_W'(pos);
        end
        if (cmd.calc2)
        begin
            total_reg <= TOT_W'(p1_reg) * TOT_W'(inner_count_reg);
            addr_reg  <= addr_full[ADDR_W-1:0];
        end
        if (commit || (cmd.emit_nodata && stat.out_free))
        begin
            out_sum_reg    <= cmd.emit ? running_sum_reg : '0;
            out_index_reg  <= cmd.emit ? IDX_W'(addr_reg) : '0;
            out_last_reg   <= cmd.emit && walk_end;
            out_status_reg <= !cmd.emit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outer_count_reg    <= CNT_W'(1);
            axis_length_reg    <= CNT_W'(1);
            inner_count_reg    <= CNT_W'(1);
            exclusive_mode_reg <= 1'b0;
            reverse_mode_reg   <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_OUTER_COUNT:    outer_count_reg    <= cfg_data;
                CFG_AXIS_LENGTH:    axis_length_reg    <= cfg_data;
                CFG_INNER_COUNT:    inner_count_reg    <= cfg_data;
                CFG_EXCLUSIVE_MODE: exclusive_mode_reg <= cfg_data[0];
                CFG_REVERSE_MODE:   reverse_mode_reg   <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_count_reg  <= '0;
            outer_pos_reg   <= '0;
            inner_pos_reg   <= '0;
            axis_step_reg   <= '0;
            running_sum_reg <= '0;
            prev_pos_reg    <= '0;
        end
        else
        begin
            if (cmd.load && room)
            begin
                load_count_reg <= load_count_reg + LOAD_W'(1);
            end
            if (cfg_hit)
            begin
                outer_pos_reg   <= '0;
                inner_pos_reg   <= '0;
                axis_step_reg   <= '0;
                running_sum_reg <= '0;
                prev_pos_reg    <= '0;
            end
            else if (cmd.sum)
            begin
                running_sum_reg <= sum_next;
            end
            else if (commit)
            begin
                if (walk_end)
                begin
                    load_count_reg  <= '0;
                    outer_pos_reg   <= '0;
                    inner_pos_reg   <= '0;
                    axis_step_reg   <= '0;
                    running_sum_reg <= '0;
                    prev_pos_reg    <= '0;
                end
                else
                begin
                    prev_pos_reg <= addr_reg;
                    if (!line_end)
                    begin
                        axis_step_reg <= step_inc[POS_W-1:0];
                    end
                    else
                    begin
                        axis_step_reg <= '0;
                        if (!plane_end)
                        begin
                            inner_pos_reg <= inner_inc[POS_W-1:0];
                        end
                        else
                        begin
                            inner_pos_reg <= '0;
                            outer_pos_reg <= outer_inc[POS_W-1:0];
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((cmd.emit || cmd.emit_nodata) && stat.out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign sum_value  = out_sum_reg;
    assign flat_index = out_index_reg;
    assign last       = out_last_reg;
    assign status     = out_status_reg;

endmodule
